@@ src/buzzer_pattern_sequencer_core_macros.svh @@
// Assertion macros for the buzzer pattern sequencer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BUZZER_PATTERN_SEQUENCER_CORE_MACROS_SVH
`define BUZZER_PATTERN_SEQUENCER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bps_pkg.sv @@
// Package for the buzzer pattern sequencer: payload types, phase codes,
// request codes, timer width and the timer saturation helper. No dependencies.
`timescale 1ns / 1ps

package bps_pkg;

    localparam int TIMER_WIDTH = 26;
    localparam int DUR_WIDTH   = 24;
    localparam int TRIPLE_WIDTH = DUR_WIDTH + 2;
    localparam int SAT_WIDTH   = 33;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    localparam logic [15:0] TICKS_PER_TENTH_RESET = 16'd100;

    localparam logic [SAT_WIDTH-1:0] TIMER_MAX =
        (SAT_WIDTH'(1) << TIMER_WIDTH) - SAT_WIDTH'(1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TO_ON,
        PH_ON,
        PH_TO_OFF,
        PH_OFF,
        PH_TO_DELAY,
        PH_DELAY
    } bps_phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] buzz_count;
        logic [7:0] duration_tenths;
        logic [7:0] repeat_count;
    } bps_in_t;

    typedef struct packed {
        logic buzzer_level;
        logic buzzer_enable;
        logic busy_res;
    } bps_out_t;

    // Clamps a wait length to the largest value the countdown can hold.
    function automatic logic [TIMER_WIDTH-1:0] sat_timer(
        input logic [TRIPLE_WIDTH-1:0] value
    );
        logic [SAT_WIDTH-1:0] wide;
        wide = SAT_WIDTH'(value);
        if (wide > TIMER_MAX)
        begin
            return TIMER_MAX[TIMER_WIDTH-1:0];
        end
        return wide[TIMER_WIDTH-1:0];
    endfunction

endpackage

@@ src/buzzer_pattern_sequencer_core.sv @@
// Top level of the buzzer pattern sequencer: phase sequencer, countdown timer
// and a two-entry result queue. Depends on bps_pkg.
`timescale 1ns / 1ps

// Every accepted item (a service tick or a start/stop command) updates the
// sequencer state in the cycle it is accepted and yields one registered
// result item, shown on out_data. The block takes one item per cycle
// indefinitely while results are taken; results go through a two-entry
// queue (output register plus skid register), so in_stall rises only when
// both entries hold results that the downstream side has not taken.
// ticks_per_tenth is written on the cfg channel, which is always ready, and
// takes effect at the next start command. Reset is asynchronous, active low.
module buzzer_pattern_sequencer_core
    import bps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  bps_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output bps_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]            ticks_per_tenth_reg;
    bps_phase_t             phase_reg, phase_next;
    logic [7:0]             buzzes_left_reg, buzzes_left_next;
    logic [7:0]             buzzes_reload_reg, buzzes_reload_next;
    logic [7:0]             repeats_left_reg, repeats_left_next;
    logic [DUR_WIDTH-1:0]   duration_ticks_reg, duration_ticks_next;
    logic [TIMER_WIDTH-1:0] countdown_reg, countdown_next;
    logic                   level_reg, level_next;
    logic                   enable_reg, enable_next;

    logic                   out_valid_reg, out_valid_next;
    bps_out_t               out_data_reg, out_data_next;
    logic                   skid_valid_reg, skid_valid_next;
    bps_out_t               skid_data_reg, skid_data_next;

    logic                   accept;
    logic                   pop;
    logic                   is_cmd;
    logic                   is_stop;
    logic [TIMER_WIDTH-1:0] countdown_dec;
    logic                   wait_done;
    logic [7:0]             repeats_dec;
    logic [TRIPLE_WIDTH-1:0] dur_ext;
    logic [TRIPLE_WIDTH-1:0] dur_triple;
    bps_out_t               result;

    assign in_stall  = skid_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign accept  = in_valid && !in_stall;
    assign pop     = out_valid_reg && !out_stall;
    assign is_cmd  = (in_data.req_type == REQ_CMD);
    assign is_stop = (in_data.repeat_count == 8'd0);

    assign countdown_dec = (countdown_reg != '0) ? countdown_reg - TIMER_WIDTH'(1)
                                                 : countdown_reg;
    assign wait_done   = (countdown_dec == '0);
    assign repeats_dec = repeats_left_reg - 8'd1;
    assign dur_ext     = TRIPLE_WIDTH'(duration_ticks_reg);
    assign dur_triple  = (dur_ext << 1) + dur_ext;

    // Phase transitions.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (is_cmd)
            begin
                phase_next = is_stop ? PH_IDLE : PH_TO_ON;
            end
            else
            begin
                unique case (phase_reg)
                    PH_TO_ON:    phase_next = PH_ON;
                    PH_ON:       phase_next = wait_done ? PH_TO_OFF : PH_ON;
                    PH_TO_OFF:   phase_next = PH_OFF;
                    PH_OFF:
                    begin
                        if (wait_done)
                        begin
                            if (buzzes_left_reg != 8'd0)
                            begin
                                phase_next = PH_TO_ON;
                            end
                            else if (repeats_dec == 8'd0)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_TO_DELAY;
                            end
                        end
                    end
                    PH_TO_DELAY: phase_next = PH_DELAY;
                    PH_DELAY:    phase_next = wait_done ? PH_ON : PH_DELAY;
                    default:     phase_next = phase_reg;
                endcase
            end
        end
    end

    // Counters, timer and pin drive that follow the phase.
    always_comb
    begin
        buzzes_left_next    = buzzes_left_reg;
        buzzes_reload_next  = buzzes_reload_reg;
        repeats_left_next   = repeats_left_reg;
        duration_ticks_next = duration_ticks_reg;
        countdown_next      = countdown_reg;
        level_next          = level_reg;
        enable_next         = enable_reg;
        if (accept)
        begin
            if (is_cmd)
            begin
                if (is_stop)
                begin
                    level_next  = 1'b0;
                    enable_next = 1'b0;
                end
                else
                begin
                    buzzes_left_next    = in_data.buzz_count;
                    buzzes_reload_next  = in_data.buzz_count;
                    repeats_left_next   = in_data.repeat_count;
                    duration_ticks_next = DUR_WIDTH'(in_data.duration_tenths)
                                          * DUR_WIDTH'(ticks_per_tenth_reg);
                    enable_next         = 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_TO_ON:
                    begin
                        level_next     = 1'b1;
                        countdown_next = sat_timer(dur_ext);
                    end
                    PH_ON:
                    begin
                        countdown_next = countdown_dec;
                    end
                    PH_TO_OFF:
                    begin
                        buzzes_left_next = buzzes_left_reg - 8'd1;
                        level_next       = 1'b0;
                        countdown_next   = sat_timer(dur_ext);
                    end
                    PH_OFF:
                    begin
                        countdown_next = countdown_dec;
                        if (wait_done && (buzzes_left_reg == 8'd0))
                        begin
                            repeats_left_next = repeats_dec;
                            if (repeats_dec == 8'd0)
                            begin
                                level_next  = 1'b0;
                                enable_next = 1'b0;
                            end
                        end
                    end
                    PH_TO_DELAY:
                    begin
                        level_next     = 1'b0;
                        countdown_next = sat_timer(dur_triple);
                    end
                    PH_DELAY:
                    begin
                        countdown_next = countdown_dec;
                        if (wait_done)
                        begin
                            buzzes_left_next = buzzes_reload_reg;
                            countdown_next   = sat_timer(dur_ext);
                            level_next       = 1'b1;
                        end
                    end
                    default:
                    begin
                        countdown_next = countdown_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.buzzer_level  = level_next;
        result.buzzer_enable = enable_next;
        result.busy_res      = (phase_next != PH_IDLE);
    end

    // Two-entry result queue. The skid entry only fills while the output
    // entry is held, and a full skid entry stalls the input side.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_tenth_reg <= TICKS_PER_TENTH_RESET;
            phase_reg           <= PH_IDLE;
            buzzes_left_reg     <= '0;
            buzzes_reload_reg   <= '0;
            repeats_left_reg    <= '0;
            duration_ticks_reg  <= '0;
            countdown_reg       <= '0;
            level_reg           <= 1'b0;
            enable_reg          <= 1'b0;
            out_valid_reg       <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ticks_per_tenth_reg <= cfg_data;
            end
            phase_reg          <= phase_next;
            buzzes_left_reg    <= buzzes_left_next;
            buzzes_reload_reg  <= buzzes_reload_next;
            repeats_left_reg   <= repeats_left_next;
            duration_ticks_reg <= duration_ticks_next;
            countdown_reg      <= countdown_next;
            level_reg          <= level_next;
            enable_reg         <= enable_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ src/bps_checker.sv @@
// Port-level checker for the buzzer pattern sequencer, bound to the top level.
// Depends on bps_pkg and buzzer_pattern_sequencer_core_macros.svh.
`timescale 1ns / 1ps
`include "buzzer_pattern_sequencer_core_macros.svh"

module bps_checker
    import bps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input bps_out_t    out_data
);

    `BPS_ASSERT_NEXT(a_out_valid_holds, out_valid && out_stall, out_valid, "result item dropped while stalled")

    `BPS_ASSERT_NEXT(a_out_data_holds, out_valid && out_stall, $stable(out_data), "stalled result item changed")

    // A pin that sounds or a running pattern needs the pin driven.
    `BPS_ASSERT_NOW(a_busy_enabled, out_valid && (out_data.busy_res || out_data.buzzer_level), out_data.buzzer_enable, "buzzer active while pin not driven")

    // An item taken while no result is pending shows up in the next cycle.
    `BPS_ASSERT_NEXT(a_result_follows, in_valid && !in_stall && !out_valid, out_valid, "accepted item produced no result item")

endmodule

bind buzzer_pattern_sequencer_core bps_checker u_bps_checker (.*);
